### rtl/mbrc_pkg.sv
// shared types and constants for the modbus rtu response checker
package mbrc_pkg;

   // request action codes
   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_EOF     = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_FUNCTION = 2'd1;
   localparam logic [1:0] CSR_LENGTH   = 2'd2;

   // csr reset values
   localparam logic [7:0] RST_ADDRESS  = 8'd0;
   localparam logic [7:0] RST_FUNCTION = 8'd0;
   localparam logic [7:0] RST_LENGTH   = 8'd8;

   // response status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CRC_ERR = 3'd1;
   localparam logic [2:0] ST_EXC     = 3'd2;
   localparam logic [2:0] ST_TRASH   = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   // frame format
   localparam logic [7:0] MIN_LENGTH    = 8'd4;
   localparam logic [7:0] CRC_BYTES     = 8'd2;
   localparam logic [7:0] EXC_FRAME_LEN = 8'd5;
   localparam logic [8:0] EXC_FLAG      = 9'h080;
   localparam logic [7:0] EXC_CODE_MIN  = 8'd1;
   localparam logic [7:0] EXC_CODE_MAX  = 8'd11;
   localparam logic [7:0] BYTE_CNT_MAX  = 8'd255;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;

   localparam int QUEUE_DEPTH_DEF = 4;

   // classified request kinds that travel through the queue
   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_EOF     = 2'd1,
      OP_TIMEOUT = 2'd2
   } mbrc_op_type;

   typedef struct packed {
      mbrc_op_type op;
      logic [7:0]  data;
   } mbrc_entry_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] function_code;
      logic [7:0] length;
   } mbrc_cfg_type;

endpackage

### rtl/mbrc_front.sv
// front end: accepts requests, classifies the action and feeds the queue
module mbrc_front
   import mbrc_pkg::*;
(
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_action,
   input  logic [7:0]     req_rx_byte,
   input  logic           q_full,
   output logic           q_push,
   output mbrc_entry_type q_entry
);

   logic accept;
   logic keep;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      keep          = 1'b1;
      q_entry.data  = req_rx_byte;
      q_entry.op    = OP_BYTE;
      case (req_action)
         ACT_BYTE: begin
            q_entry.op = OP_BYTE;
         end
         ACT_EOF: begin
            q_entry.op = OP_EOF;
         end
         ACT_TIMEOUT: begin
            q_entry.op = OP_TIMEOUT;
         end
         default: begin
            // unused action is swallowed
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = accept && keep;

endmodule

### rtl/mbrc_queue.sv
// small fifo between the front end and the frame engine
module mbrc_queue
   import mbrc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mbrc_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output mbrc_entry_type head_entry
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mbrc_entry_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> count_ff == CntW'(Depth))
      else $error("queue lost an entry while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

### rtl/mbrc_back.sv
// frame engine: crc, byte capture, end of frame classification, counters
module mbrc_back
   import mbrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mbrc_cfg_type   cfg,
   input  logic           head_valid,
   input  mbrc_entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [2:0]     rsp_status,
   output logic [3:0]     rsp_exception_code,
   output logic [31:0]    rsp_ok_count,
   output logic [31:0]    rsp_crc_error_count,
   output logic [31:0]    rsp_exception_count,
   output logic [31:0]    rsp_lost_count,
   output logic [31:0]    rsp_trash_count
);

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  third_ff, third_in;
   logic [15:0] crc_run_ff, crc_run_in;
   logic [15:0] crc_rx_ff, crc_rx_in;
   logic [31:0] ok_ff, crc_err_ff, exc_ff, lost_ff, trash_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [3:0]  code_ff, code_in;

   logic        out_free;
   logic        inc_ok, inc_crc, inc_exc, inc_lost, inc_trash;
   logic [7:0]  eff_len, len_m2, len_m1;
   logic        is_exc, is_match;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && ((head_entry.op == OP_BYTE) || out_free);

   assign eff_len = (cfg.length < MIN_LENGTH) ? MIN_LENGTH : cfg.length;
   assign len_m2  = eff_len - CRC_BYTES;
   assign len_m1  = eff_len - 8'd1;

   assign is_exc = (byte_count_ff == EXC_FRAME_LEN) && (first_ff == cfg.address)
                && ({1'b0, second_ff} == ({1'b0, cfg.function_code} + EXC_FLAG))
                && (third_ff >= EXC_CODE_MIN) && (third_ff <= EXC_CODE_MAX);
   assign is_match = (byte_count_ff >= eff_len) && (first_ff == cfg.address)
                  && (second_ff == cfg.function_code);

   always_comb begin
      byte_count_in = byte_count_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      third_in      = third_ff;
      crc_run_in    = crc_run_ff;
      crc_rx_in     = crc_rx_ff;
      status_in     = status_ff;
      code_in       = code_ff;
      inc_ok        = 1'b0;
      inc_crc       = 1'b0;
      inc_exc       = 1'b0;
      inc_lost      = 1'b0;
      inc_trash     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (pop) begin
         case (head_entry.op)
            OP_BYTE: begin
               if (byte_count_ff == 8'd0) first_in = head_entry.data;
               if (byte_count_ff == 8'd1) second_in = head_entry.data;
               if (byte_count_ff == 8'd2) third_in = head_entry.data;
               if (byte_count_ff != BYTE_CNT_MAX) begin
                  if (byte_count_ff < len_m2) begin
                     crc_run_in = crc_step(crc_run_ff, head_entry.data);
                  end else if (byte_count_ff == len_m2) begin
                     crc_rx_in = {crc_rx_ff[15:8], head_entry.data};
                  end else if (byte_count_ff == len_m1) begin
                     crc_rx_in = {head_entry.data, crc_rx_ff[7:0]};
                  end
                  byte_count_in = byte_count_ff + 8'd1;
               end
            end
            OP_EOF, OP_TIMEOUT: begin
               rsp_valid_in = 1'b1;
               code_in      = 4'd0;
               if (head_entry.op == OP_TIMEOUT) begin
                  status_in = ST_TIMEOUT;
                  inc_lost  = 1'b1;
               end else if (is_exc) begin
                  status_in = ST_EXC;
                  code_in   = third_ff[3:0];
                  inc_exc   = 1'b1;
               end else if (is_match) begin
                  if (crc_rx_ff == crc_run_ff) begin
                     status_in = ST_OK;
                     inc_ok    = 1'b1;
                  end else begin
                     status_in = ST_CRC_ERR;
                     inc_crc   = 1'b1;
                  end
               end else begin
                  status_in = ST_TRASH;
                  inc_trash = 1'b1;
               end
               // frame state back to idle
               byte_count_in = 8'd0;
               first_in      = 8'd0;
               second_in     = 8'd0;
               third_in      = 8'd0;
               crc_run_in    = CRC_INIT;
               crc_rx_in     = 16'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 8'd0;
         first_ff      <= 8'd0;
         second_ff     <= 8'd0;
         third_ff      <= 8'd0;
         crc_run_ff    <= CRC_INIT;
         crc_rx_ff     <= 16'd0;
         ok_ff         <= 32'd0;
         crc_err_ff    <= 32'd0;
         exc_ff        <= 32'd0;
         lost_ff       <= 32'd0;
         trash_ff      <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         third_ff      <= third_in;
         crc_run_ff    <= crc_run_in;
         crc_rx_ff     <= crc_rx_in;
         ok_ff         <= ok_ff + {31'd0, inc_ok};
         crc_err_ff    <= crc_err_ff + {31'd0, inc_crc};
         exc_ff        <= exc_ff + {31'd0, inc_exc};
         lost_ff       <= lost_ff + {31'd0, inc_lost};
         trash_ff      <= trash_ff + {31'd0, inc_trash};
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      code_ff   <= code_in;
   end

   // counters only move when a new response is loaded, so they are the payload
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_exception_code  = code_ff;
   assign rsp_ok_count        = ok_ff;
   assign rsp_crc_error_count = crc_err_ff;
   assign rsp_exception_count = exc_ff;
   assign rsp_lost_count      = lost_ff;
   assign rsp_trash_count     = trash_ff;

   a_one_counter: assert property (@(posedge clock) disable iff (reset)
      $onehot0({inc_ok, inc_crc, inc_exc, inc_lost, inc_trash}))
      else $error("more than one counter bumped");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      pop && (head_entry.op != OP_BYTE) |=> rsp_valid_ff && !$stable(
         {ok_ff, crc_err_ff, exc_ff, lost_ff, trash_ff}))
      else $error("end of frame or timeout gave no response");

   a_exc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_EXC) |-> (code_ff >= 4'd1) && (code_ff <= 4'd11))
      else $error("exception response with bad code");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_EXC) |-> code_ff == 4'd0)
      else $error("non-exception response with nonzero code");

endmodule

### rtl/modbus_rtu_response_checker_unit.sv
// top level of the modbus rtu response checker
//
// usage: the request channel (req_valid / req_stall) carries one request per
// accepted cycle: a received byte, an end of frame or a response timeout.
// bytes produce no response; each end of frame or timeout produces one response
// on the rsp channel with its status, exception code and all five counters.
// the csr port writes expected address, function and length; write it only
// while the checker is idle.
// a request is written into the queue; an end of frame or timeout leaves the queue
// head once the previous response has been taken and loads the response register.
// throughput: one request per cycle while req_stall is low; the per-byte crc update
// is a single eight-step combinational stage in the frame engine.
// a short queue sits between the request front end and the frame engine. while
// the receiver stalls, the response holds and bytes ahead of the next end of
// frame or timeout keep flowing into the crc; that end of frame or timeout waits
// at the queue head, later requests pile up behind it, and req_stall rises once
// the queue is full.
// reset (synchronous) empties the queue, clears the frame state and counters and
// sets the csr registers to address 0, function 0, length 8.
module modbus_rtu_response_checker_unit
   import mbrc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_exception_code,
   output logic [31:0] rsp_ok_count,
   output logic [31:0] rsp_crc_error_count,
   output logic [31:0] rsp_exception_count,
   output logic [31:0] rsp_lost_count,
   output logic [31:0] rsp_trash_count,
   // csr write port
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   // csr registers
   mbrc_cfg_type cfg_ff, cfg_in;

   // front to queue
   logic           q_push;
   logic           q_full;
   mbrc_entry_type q_entry;

   // queue to frame engine
   logic           q_pop;
   logic           q_head_valid;
   mbrc_entry_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ADDRESS:  cfg_in.address       = csr_write_data;
            CSR_FUNCTION: cfg_in.function_code = csr_write_data;
            CSR_LENGTH:   cfg_in.length        = csr_write_data;
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address       <= RST_ADDRESS;
         cfg_ff.function_code <= RST_FUNCTION;
         cfg_ff.length        <= RST_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request front end: classify action, drop the unused code
   mbrc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // decoupling queue
   mbrc_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   // frame engine with response register
   mbrc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head_valid          (q_head_valid),
      .head_entry          (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_exception_code  (rsp_exception_code),
      .rsp_ok_count        (rsp_ok_count),
      .rsp_crc_error_count (rsp_crc_error_count),
      .rsp_exception_count (rsp_exception_count),
      .rsp_lost_count      (rsp_lost_count),
      .rsp_trash_count     (rsp_trash_count)
   );

endmodule

### verif/modbus_rtu_response_checker_unit_test.sv
// self-checking testbench for the modbus rtu response checker unit
`timescale 1ns / 1ps

module modbus_rtu_response_checker_unit_test
   import mbrc_pkg::*;
();

   localparam int          ITEMS_WANTED = 1700;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  code;
      logic [31:0] ok_total;
      logic [31:0] crc_total;
      logic [31:0] exc_total;
      logic [31:0] lost_total;
      logic [31:0] trash_total;
   } verdict_type;

   typedef enum {
      FR_GOOD, FR_BAD_CRC, FR_LONGER, FR_EXCEPTION, FR_EXC_ODD,
      FR_SHORT, FR_FOREIGN, FR_NOISE, FR_TIMEOUT
   } frame_shape_type;

   // mirror of the checker: registers, frame state and totals, plus the
   // verdicts still owed by the block
   class rtu_verdict_board;
      mbrc_cfg_type regs;
      logic [7:0]   bytes_in;
      logic [7:0]   addr_seen;
      logic [7:0]   func_seen;
      logic [7:0]   code_seen;
      logic [15:0]  crc_acc;
      logic [15:0]  crc_rx;
      logic [31:0]  tally [5];
      verdict_type  due [$];
      int           failures;

      function new();
         regs.address       = RST_ADDRESS;
         regs.function_code = RST_FUNCTION;
         regs.length        = RST_LENGTH;
         foreach (tally[i]) tally[i] = '0;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         bytes_in  = '0;
         addr_seen = '0;
         func_seen = '0;
         code_seen = '0;
         crc_acc   = CRC_INIT;
         crc_rx    = '0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_ADDRESS:  regs.address = value;
            CSR_FUNCTION: regs.function_code = value;
            CSR_LENGTH:   regs.length = value;
            default: ;
         endcase
      endfunction

      function int effective_length();
         return (regs.length < MIN_LENGTH) ? int'(MIN_LENGTH) : int'(regs.length);
      endfunction

      // crc-16 modbus, one byte, lsb first
      function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function void take_byte(logic [7:0] b);
         int idx;
         int eff;
         idx = bytes_in;
         eff = effective_length();
         if (idx == 0) addr_seen = b;
         else if (idx == 1) func_seen = b;
         else if (idx == 2) code_seen = b;
         // past the 255th byte nothing is captured any more
         if (idx < BYTE_CNT_MAX) begin
            if (idx < eff - CRC_BYTES) crc_acc = crc_next(crc_acc, b);
            else if (idx == eff - CRC_BYTES) crc_rx[7:0] = b;
            else if (idx == eff - 1) crc_rx[15:8] = b;
            bytes_in = bytes_in + 8'd1;
         end
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] b);
         verdict_type v;
         logic [2:0]  st;
         v  = '0;
         st = ST_TRASH;
         case (act)
            ACT_BYTE: begin
               take_byte(b);
               return;
            end
            ACT_EOF: begin
               // exception pattern is checked first, function plus flag at 9 bits
               if (bytes_in == EXC_FRAME_LEN && addr_seen == regs.address &&
                   {1'b0, func_seen} == {1'b0, regs.function_code} + EXC_FLAG &&
                   code_seen >= EXC_CODE_MIN && code_seen <= EXC_CODE_MAX) begin
                  st     = ST_EXC;
                  v.code = code_seen[3:0];
               end else if (bytes_in >= effective_length() && addr_seen == regs.address &&
                            func_seen == regs.function_code) begin
                  st = (crc_rx == crc_acc) ? ST_OK : ST_CRC_ERR;
               end
            end
            ACT_TIMEOUT: st = ST_TIMEOUT;
            default: return;
         endcase
         tally[st]     = tally[st] + 32'd1;
         v.status      = st;
         v.ok_total    = tally[ST_OK];
         v.crc_total   = tally[ST_CRC_ERR];
         v.exc_total   = tally[ST_EXC];
         v.lost_total  = tally[ST_TIMEOUT];
         v.trash_total = tally[ST_TRASH];
         due.push_back(v);
         clear_frame();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(verdict_type got);
         verdict_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %0d",
                     $time, got.status);
            failures++;
            return;
         end
         want = due.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("exception_code", want.code, got.code);
         compare_field("ok_count", want.ok_total, got.ok_total);
         compare_field("crc_error_count", want.crc_total, got.crc_total);
         compare_field("exception_count", want.exc_total, got.exc_total);
         compare_field("lost_count", want.lost_total, got.lost_total);
         compare_field("trash_count", want.trash_total, got.trash_total);
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action     = ACT_BYTE;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_exception_code;
   logic [31:0] rsp_ok_count;
   logic [31:0] rsp_crc_error_count;
   logic [31:0] rsp_exception_count;
   logic [31:0] rsp_lost_count;
   logic [31:0] rsp_trash_count;
   logic        csr_write_en   = 1'b0;
   logic [1:0]  csr_index      = CSR_ADDRESS;
   logic [7:0]  csr_write_data = 8'h00;

   rtu_verdict_board book;
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  steady      = 1'b0;   // no idling on either side while set
   int  stall_left  = 0;
   bit  stall_hold  = 1'b0;

   modbus_rtu_response_checker_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_exception_code  (rsp_exception_code),
      .rsp_ok_count        (rsp_ok_count),
      .rsp_crc_error_count (rsp_crc_error_count),
      .rsp_exception_count (rsp_exception_count),
      .rsp_lost_count      (rsp_lost_count),
      .rsp_trash_count     (rsp_trash_count),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_rtu_response_checker_unit_test NOT OK");
         $finish;
      end
   end

   // receiver back-pressure: runs of free cycles, short stalls and a few long ones
   always @(posedge clock) begin
      int r;
      if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            r = $urandom_range(99);
            if (r < 55) begin
               stall_hold = 1'b0;
               stall_left = $urandom_range(20, 1);
            end else if (r < 93) begin
               stall_hold = 1'b1;
               stall_left = $urandom_range(3, 1);
            end else begin
               stall_hold = 1'b1;
               stall_left = $urandom_range(40, 10);
            end
         end
         stall_left = stall_left - 1;
         rsp_stall <= stall_hold;
      end
   end

   // response monitor
   always @(posedge clock) begin
      verdict_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status      = rsp_status;
         seen.code        = rsp_exception_code;
         seen.ok_total    = rsp_ok_count;
         seen.crc_total   = rsp_crc_error_count;
         seen.exc_total   = rsp_exception_count;
         seen.lost_total  = rsp_lost_count;
         seen.trash_total = rsp_trash_count;
         book.check_response(seen);
      end
   end

   function automatic int idle_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   function automatic frame_shape_type pick_shape();
      int r;
      r = $urandom_range(99);
      if (r < 28) return FR_GOOD;
      if (r < 38) return FR_BAD_CRC;
      if (r < 46) return FR_LONGER;
      if (r < 61) return FR_EXCEPTION;
      if (r < 68) return FR_EXC_ODD;
      if (r < 76) return FR_SHORT;
      if (r < 84) return FR_FOREIGN;
      if (r < 91) return FR_NOISE;
      return FR_TIMEOUT;
   endfunction

   // called at a clock edge; returns at the edge that accepts the request
   task automatic send_request(input logic [1:0] act, input logic [7:0] b);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(act, b);
      if (act != ACT_UNUSED) items_sent++;
   endtask

   // hold off until every response is in and queued bytes have drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] a, input logic [7:0] f,
                               input logic [7:0] l);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ADDRESS;
      csr_write_data <= a;
      @(posedge clock);
      csr_index      <= CSR_FUNCTION;
      csr_write_data <= f;
      @(posedge clock);
      csr_index      <= CSR_LENGTH;
      csr_write_data <= l;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      book.set_register(CSR_ADDRESS, a);
      book.set_register(CSR_FUNCTION, f);
      book.set_register(CSR_LENGTH, l);
   endtask

   task automatic send_frame(input frame_shape_type shape);
      logic [7:0]  octets [$];
      logic [7:0]  a;
      logic [7:0]  f;
      logic [15:0] crc;
      int          eff;
      int          cut;
      int          k;
      a   = book.regs.address;
      f   = book.regs.function_code;
      eff = book.effective_length();
      case (shape)
         FR_EXCEPTION, FR_EXC_ODD: begin
            octets.push_back(a);
            octets.push_back(f + 8'h80);
            octets.push_back(8'($urandom_range(11, 1)));
            octets.push_back(8'($urandom));
            octets.push_back(8'($urandom));
            // near misses of the exception pattern
            if (shape == FR_EXC_ODD) begin
               case ($urandom_range(3))
                  0: octets[2] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 12));
                  1: octets.push_back(8'($urandom));
                  2: void'(octets.pop_back());
                  default: octets[0] = a ^ 8'($urandom_range(255, 1));
               endcase
            end
         end
         FR_NOISE: begin
            repeat ($urandom_range(12)) octets.push_back(8'($urandom));
         end
         default: begin
            octets.push_back(a);
            octets.push_back(f);
            while (octets.size() < eff - 2) octets.push_back(8'($urandom));
            crc = CRC_INIT;
            foreach (octets[i]) crc = book.crc_next(crc, octets[i]);
            octets.push_back(crc[7:0]);
            octets.push_back(crc[15:8]);
            case (shape)
               FR_BAD_CRC: begin
                  k = $urandom_range(eff - 1, 2);
                  octets[k] = octets[k] ^ 8'(1 << $urandom_range(7));
               end
               FR_LONGER: repeat ($urandom_range(3, 1)) octets.push_back(8'($urandom));
               FR_SHORT: begin
                  cut = $urandom_range(eff - 1);
                  while (octets.size() > cut) void'(octets.pop_back());
               end
               FR_FOREIGN: begin
                  k = $urandom_range(1);
                  octets[k] = octets[k] ^ 8'($urandom_range(255, 1));
               end
               FR_TIMEOUT: begin
                  cut = $urandom_range(octets.size());
                  while (octets.size() > cut) void'(octets.pop_back());
               end
               default: ;
            endcase
         end
      endcase
      foreach (octets[i]) begin
         if ($urandom_range(49) == 0) send_request(ACT_UNUSED, 8'($urandom));
         send_request(ACT_BYTE, octets[i]);
      end
      send_request(shape == FR_TIMEOUT ? ACT_TIMEOUT : ACT_EOF, 8'($urandom));
   endtask

   initial begin
      logic [15:0] crc;
      logic [7:0]  a;
      logic [7:0]  f;
      logic [7:0]  l;
      int          r;
      int          phase;
      book  = new();
      phase = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty frame, ignored action and a lost response at reset values
      send_request(ACT_EOF, 8'hFF);
      send_request(ACT_UNUSED, 8'hA5);
      send_request(ACT_TIMEOUT, 8'h5A);

      // length below the minimum acts as four
      wait_idle();
      write_config(8'hFF, 8'h7F, 8'h00);
      send_frame(FR_GOOD);
      send_frame(FR_EXCEPTION);

      // length register changed halfway through a frame
      wait_idle();
      write_config(8'hFF, 8'h7F, 8'hFF);
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_BYTE, 8'h7F);
      wait_idle();
      write_config(8'hFF, 8'h7F, 8'h04);
      crc = book.crc_next(book.crc_next(CRC_INIT, 8'hFF), 8'h7F);
      send_request(ACT_BYTE, crc[7:0]);
      send_request(ACT_BYTE, crc[15:8]);
      send_request(ACT_EOF, 8'h00);

      // random phases, each opening from an idle block with fresh registers
      while (items_sent < ITEMS_WANTED) begin
         phase++;
         wait_idle();
         steady = ($urandom_range(4) == 0);
         if (phase == 4) begin
            // longest frames, plus bytes past the 255th
            write_config(8'($urandom), 8'($urandom_range(127)), 8'hFF);
            send_frame(FR_GOOD);
            send_frame(FR_LONGER);
         end else begin
            r = $urandom_range(99);
            a = (r < 20) ? 8'h00 : (r < 40) ? 8'hFF : 8'($urandom);
            r = $urandom_range(99);
            f = (r < 15) ? 8'h00 : (r < 30) ? 8'h7F : (r < 40) ? 8'h80 :
                (r < 45) ? 8'hFF : 8'($urandom_range(127));
            r = $urandom_range(99);
            l = (r < 12) ? 8'($urandom_range(3)) : (r < 25) ? MIN_LENGTH :
                8'($urandom_range(12, 5));
            write_config(a, f, l);
            repeat ($urandom_range(12, 3)) send_frame(pick_shape());
         end
      end

      steady = 1'b0;
      wait_idle();
      if (book.failures == 0 && book.due.size() == 0) begin
         $display("modbus_rtu_response_checker_unit_test OK");
      end else begin
         $display("modbus_rtu_response_checker_unit_test NOT OK");
      end
      $finish;
   end

endmodule
